// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the rtl checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/erg_pkg.sv =====
// ----------------------------------------------------------------------------
// erg_pkg
// widths, defaults and the control type of the euclidean rhythm generator
// ----------------------------------------------------------------------------
package erg_pkg;

   localparam int STEPS_W       = 7;
   localparam int HITS_W        = 8;
   localparam int ROT_W         = 8;
   localparam int RHYTHM_W      = 64;
   localparam int TOTAL_W       = 7;
   localparam int MAX_STEPS_DEF = 64;

   // load and advance strobes for a serial unit
   typedef struct packed {
      logic load;
      logic step;
   } erg_ctl_type;

endpackage

// ===== hw/rtl/euclidean_rhythm_generator.sv =====
// one item at a time: start is taken only while busy is low
// busy drops in the cycle after rsp_valid
// each item runs the 8-bit serial modulo, then the one-step-per-cycle bresenham loop
// each result is shown for one cycle only; the receiver cannot stall
// reset is synchronous, active high, and returns the sequencer to idle
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator
// builds an n-step euclidean rhythm, rotated within its window, and its hit count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euclidean_rhythm_generator #(
   parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [erg_pkg::STEPS_W-1:0]   req_steps,
   input  logic [erg_pkg::HITS_W-1:0]    req_hits,
   input  logic [erg_pkg::ROT_W-1:0]     req_rotation,
   output logic                          rsp_valid,
   output logic [erg_pkg::RHYTHM_W-1:0]  rsp_rhythm,
   output logic [erg_pkg::TOTAL_W-1:0]   rsp_hit_total
);
   import erg_pkg::*;

   // sequencer: load, serial modulo, seed the spreader, walk the steps, show result
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_SEED = 5'b00100,
      ST_GEN  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEPS_W-1:0]   cnt_ff, cnt_in;
   logic [STEPS_W-1:0]   n_ff, n_in;
   logic [STEPS_W-1:0]   k_ff, k_in;
   logic                 accept;
   logic [STEPS_W-1:0]   n_sat;
   erg_ctl_type          div_ctl;
   erg_ctl_type          spr_ctl;
   logic [STEPS_W-1:0]   rot_mod;
   logic [MAX_STEPS-1:0] spr_bits;
   logic [TOTAL_W-1:0]   spr_total;

   assign accept = start && !busy;

   // step count saturates at the configured maximum, hits clamp to the step count
   assign n_sat = (req_steps > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS) : req_steps;

   always_comb begin
      n_in = n_ff;
      k_in = k_ff;
      if (accept) begin
         n_in = n_sat;
         k_in = (req_hits > {1'b0, n_sat}) ? n_sat : req_hits[STEPS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      k_ff <= k_in;
   end

   // sequencer next state; cnt counts modulo bits, then pattern steps
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + STEPS_W'(1);
            if (cnt_ff == STEPS_W'(ROT_W - 1)) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cnt_in = '0;
            // empty pattern skips the step walk; the seed already cleared it
            state_in = (n_ff == '0) ? ST_RESP : ST_GEN;
         end
         ST_GEN: begin
            cnt_in = cnt_ff + STEPS_W'(1);
            if (cnt_ff == (n_ff - STEPS_W'(1))) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // rotation mod n, one rotation bit per cycle
   assign div_ctl.load = accept;
   assign div_ctl.step = (state_ff == ST_DIV);

   erg_divider u_divider (
      .clock     (clock),
      .ctl       (div_ctl),
      .dividend  (req_rotation),
      .divisor   (n_in),
      .remainder (rot_mod)
   );

   // step i of the pattern lands at slot (i + rotation) mod n, which is the rotation
   assign spr_ctl.load = (state_ff == ST_SEED);
   assign spr_ctl.step = (state_ff == ST_GEN);

   erg_spreader #(
      .MAX_STEPS (MAX_STEPS)
   ) u_spreader (
      .clock  (clock),
      .ctl    (spr_ctl),
      .n      (n_ff),
      .k      (k_ff),
      .offset (rot_mod),
      .bits   (spr_bits),
      .total  (spr_total)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_RESP);
   assign rsp_rhythm    = RHYTHM_W'(spr_bits);
   assign rsp_hit_total = spr_total;

   // checks
   `ASSERT_NEXT(a_one_result, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "not busy after accepting an item")
   `ASSERT_IMPLY(a_total_bound, clock, reset, rsp_valid, rsp_hit_total <= n_ff, "hit count above steps")
   `ASSERT_IMPLY(a_gen_count, clock, reset, state_ff == ST_GEN, cnt_ff < n_ff, "step walk overran")

endmodule

// ===== hw/rtl/erg_divider.sv =====
// ----------------------------------------------------------------------------
// erg_divider
// restoring remainder unit, one dividend bit per cycle while step is high
// ----------------------------------------------------------------------------
module erg_divider (
   input  logic                         clock,
   input  erg_pkg::erg_ctl_type         ctl,
   input  logic [erg_pkg::ROT_W-1:0]    dividend,
   input  logic [erg_pkg::STEPS_W-1:0]  divisor,
   output logic [erg_pkg::STEPS_W-1:0]  remainder
);
   import erg_pkg::*;

   logic [ROT_W-1:0]   dvd_ff, dvd_in;
   logic [STEPS_W-1:0] rem_ff, rem_in;
   logic [STEPS_W-1:0] rem_shift;
   logic               ge;

   // remainder stays below the divisor (at most 64), so it fits in six bits
   assign rem_shift = {rem_ff[STEPS_W-2:0], dvd_ff[ROT_W-1]};
   assign ge        = (rem_shift >= divisor);

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (ctl.load) begin
         dvd_in = dividend;
         rem_in = '0;
      end else if (ctl.step) begin
         dvd_in = {dvd_ff[ROT_W-2:0], 1'b0};
         rem_in = ge ? (rem_shift - divisor) : rem_shift;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/erg_spreader.sv =====
// ----------------------------------------------------------------------------
// erg_spreader
// bresenham hit spreader, one step per cycle while step is high, written at the rotated slot
// ----------------------------------------------------------------------------
module erg_spreader #(
   parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
   input  logic                         clock,
   input  erg_pkg::erg_ctl_type         ctl,
   input  logic [erg_pkg::STEPS_W-1:0]  n,
   input  logic [erg_pkg::STEPS_W-1:0]  k,
   input  logic [erg_pkg::STEPS_W-1:0]  offset,
   output logic [MAX_STEPS-1:0]         bits,
   output logic [erg_pkg::TOTAL_W-1:0]  total
);
   import erg_pkg::*;

   localparam int PTR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   logic [STEPS_W-1:0]   acc_ff, acc_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [MAX_STEPS-1:0] bits_ff, bits_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [STEPS_W:0]     sum;
   logic                 ge;
   logic                 hit;
   logic                 last;

   assign sum  = {1'b0, acc_ff} + {1'b0, k};
   assign ge   = (sum >= {1'b0, n});
   assign hit  = ge && (k != '0);
   assign last = (STEPS_W'(ptr_ff) == (n - STEPS_W'(1)));

   always_comb begin
      acc_in   = acc_ff;
      ptr_in   = ptr_ff;
      bits_in  = bits_ff;
      total_in = total_ff;
      if (ctl.load) begin
         acc_in   = n - k;
         ptr_in   = PTR_W'(offset);
         bits_in  = '0;
         total_in = '0;
      end else if (ctl.step) begin
         acc_in          = ge ? STEPS_W'(sum - {1'b0, n}) : sum[STEPS_W-1:0];
         bits_in[ptr_ff] = hit;
         ptr_in          = last ? '0 : (ptr_ff + PTR_W'(1));
         total_in        = total_ff + TOTAL_W'(hit);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      ptr_ff   <= ptr_in;
      bits_ff  <= bits_in;
      total_ff <= total_in;
   end

   assign bits  = bits_ff;
   assign total = total_ff;

endmodule
